// ===== hw/rtl/psci_pkg.sv =====
// ----------------------------------------------------------------------------
// psci_pkg: shared types and constants for the charge integrator
// Field widths, register indexes and reset values, sequencer states and the
// control groups that pass between the integrator's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psci_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int TIME_SAMPLES = 1024;

  localparam int ADC_W      = 16;
  localparam int CHAN_W     = 5;
  localparam int TIME_W     = 10;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 27;
  localparam int EVT_W      = 16;
  localparam int CHARGE_W   = 35;
  localparam int Q_FRAC     = 8;

  // Working width of the shared adder and the dividend width of the divider.
  localparam int ACC_W      = 48;
  localparam int DIV_W      = ACC_W - 1;
  localparam int REM_W      = CNT_W;
  localparam int STEP_W     = 6;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CHAN_W-1:0] RST_CHANNEL_SELECT = CHAN_W'(0);
  localparam logic [TIME_W-1:0] RST_PED_FIRST      = TIME_W'(1);
  localparam logic [CNT_W-1:0]  RST_PED_COUNT      = CNT_W'(50);
  localparam logic [TIME_W-1:0] RST_INT_FIRST      = TIME_W'(50);
  localparam logic [CNT_W-1:0]  RST_INT_COUNT      = CNT_W'(350);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CHANNEL_SELECT = 3'd0,
    REG_PED_FIRST      = 3'd1,
    REG_PED_COUNT      = 3'd2,
    REG_INT_FIRST      = 3'd3,
    REG_INT_COUNT      = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_NEGW,
    S_MUL,
    S_ABS,
    S_DIV,
    S_SIGN,
    S_DONE
  } calc_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic take;
    logic clear;
  } accum_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } calc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pedestal_subtracted_charge_integrator.sv =====
// ----------------------------------------------------------------------------
// pedestal_subtracted_charge_integrator: baseline-subtracted charge integration
// Input beats carry one tagged waveform sample each; tlast marks the last
// sample of an event. Samples of the selected channel are summed over the
// pedestal window and the integration window. On the tlast beat one output
// beat carries int_count*(ped_sum/ped_count) - int_sum in signed Q8,
// truncated toward zero and saturated, with a wrapping event number.
// Ordinary samples are taken one beat per cycle. After a tlast beat the
// input is held off while the charge is formed on one shared adder in
// 11 multiply steps plus 47 divide steps (dominated by the divider), or
// without them when ped_count is zero. The result then sits in an output
// register, ready again for input the cycle after it is loaded.
// If the receiver stalls, new samples are still taken; a second event end
// waits in the sequencer until the output register frees up.
// Reset clears both sums, the event counter and the output valid, and sets
// the window registers to their defaults. Write configuration only while
// no event computation is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module pedestal_subtracted_charge_integrator import psci_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata: adc_value[15:0], chan_index[20:16], time_index[30:21], zero pad
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  // m_tdata: charge_q8[34:0], event_number[50:35], zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CHAN_W-1:0]   channel_select;
  logic [TIME_W-1:0]   ped_first;
  logic [CNT_W-1:0]    ped_count;
  logic [TIME_W-1:0]   int_first;
  logic [CNT_W-1:0]    int_count;

  logic [EVT_W-1:0]    event_count;
  logic [CHARGE_W-1:0] out_charge;
  logic [EVT_W-1:0]    out_event;

  logic [ADC_W-1:0]    adc_value;
  logic [CHAN_W-1:0]   chan_index;
  logic [TIME_W-1:0]   time_index;
  logic                in_beat;
  logic                out_free;

  accum_ctl_t          acc_ctl;
  calc_stat_t          calc_stat;
  logic [SUM_W-1:0]    ped_sum;
  logic [SUM_W-1:0]    win_sum;
  logic [CHARGE_W-1:0] charge;

  assign adc_value  = s_tdata[ADC_W-1:0];
  assign chan_index = s_tdata[ADC_W+CHAN_W-1:ADC_W];
  assign time_index = s_tdata[ADC_W+CHAN_W+TIME_W-1:ADC_W+CHAN_W];

  assign s_tready = !calc_stat.busy;
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign acc_ctl.take  = in_beat;
  assign acc_ctl.clear = calc_stat.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= RST_CHANNEL_SELECT;
      ped_first      <= RST_PED_FIRST;
      ped_count      <= RST_PED_COUNT;
      int_first      <= RST_INT_FIRST;
      int_count      <= RST_INT_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CHANNEL_SELECT: channel_select <= cfg_data[CHAN_W-1:0];
        REG_PED_FIRST:      ped_first      <= cfg_data[TIME_W-1:0];
        REG_PED_COUNT:      ped_count      <= cfg_data[CNT_W-1:0];
        REG_INT_FIRST:      int_first      <= cfg_data[TIME_W-1:0];
        REG_INT_COUNT:      int_count      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  psci_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .ctl            (acc_ctl),
    .adc_value      (adc_value),
    .chan_index     (chan_index),
    .time_index     (time_index),
    .channel_select (channel_select),
    .ped_first      (ped_first),
    .ped_count      (ped_count),
    .int_first      (int_first),
    .int_count      (int_count),
    .ped_sum        (ped_sum),
    .win_sum        (win_sum)
  );

  psci_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .start     (in_beat && s_tlast),
    .ped_sum   (ped_sum),
    .win_sum   (win_sum),
    .ped_count (ped_count),
    .int_count (int_count),
    .out_free  (out_free),
    .stat      (calc_stat),
    .charge    (charge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      event_count <= '0;
    end else if (calc_stat.done) begin
      m_tvalid    <= 1'b1;
      event_count <= event_count + 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_stat.done) begin
      out_charge <= charge;
      out_event  <= event_count;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-CHARGE_W-EVT_W){1'b0}}, out_event, out_charge};

`ifndef SYNTHESIS
  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    calc_stat.done |=> m_tvalid)
    else $error("finished event did not present an output beat");

  a_event_advances: assert property (@(posedge clk) disable iff (rst)
    calc_stat.done |=> (event_count == $past(event_count) + 1'b1))
    else $error("event counter did not advance on a finished event");

  a_last_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still open after an end-of-event beat");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    calc_stat.done |=> (ped_sum == '0) && (win_sum == '0))
    else $error("window sums not cleared after an event");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/psci_alu.sv =====
// ----------------------------------------------------------------------------
// psci_alu: shared add/subtract unit
// One wide adder used by every step of the end-of-event computation.
// ----------------------------------------------------------------------------
`default_nettype none

module psci_alu import psci_pkg::*; (
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  input  alu_op_t          op,
  output logic [ACC_W-1:0] y
);

  assign y = (op == ALU_SUB) ? (a - b) : (a + b);

endmodule

`default_nettype wire

// ===== hw/rtl/psci_accum.sv =====
// ----------------------------------------------------------------------------
// psci_accum: pedestal and integration window sums
// Adds each sample of the selected channel into the window sums it falls in.
// ----------------------------------------------------------------------------
`default_nettype none

module psci_accum import psci_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  accum_ctl_t        ctl,
  input  logic [ADC_W-1:0]  adc_value,
  input  logic [CHAN_W-1:0] chan_index,
  input  logic [TIME_W-1:0] time_index,
  input  logic [CHAN_W-1:0] channel_select,
  input  logic [TIME_W-1:0] ped_first,
  input  logic [CNT_W-1:0]  ped_count,
  input  logic [TIME_W-1:0] int_first,
  input  logic [CNT_W-1:0]  int_count,
  output logic [SUM_W-1:0]  ped_sum,
  output logic [SUM_W-1:0]  win_sum
);

  logic             hit;
  logic             in_ped;
  logic             in_int;
  logic [TIME_W-1:0] ped_off;
  logic [TIME_W-1:0] int_off;
  logic [SUM_W-1:0] sample;

  assign sample  = {{(SUM_W-ADC_W){adc_value[ADC_W-1]}}, adc_value};
  assign ped_off = time_index - ped_first;
  assign int_off = time_index - int_first;

  assign hit    = (chan_index == channel_select) && (int'(chan_index) < NUM_CHANNELS) &&
                  (int'(time_index) < TIME_SAMPLES);
  assign in_ped = (time_index >= ped_first) && ({1'b0, ped_off} < ped_count);
  assign in_int = (time_index >= int_first) && ({1'b0, int_off} < int_count);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      ped_sum <= '0;
      win_sum <= '0;
    end else if (ctl.take && hit) begin
      if (in_ped) begin
        ped_sum <= ped_sum + sample;
      end
      if (in_int) begin
        win_sum <= win_sum + sample;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/psci_calc.sv =====
// ----------------------------------------------------------------------------
// psci_calc: end-of-event charge sequencer
// Forms int_count*ped_sum - ped_count*win_sum by shift-and-add, scales it to
// Q8, divides by ped_count one quotient bit per cycle and saturates, all on
// the one shared adder. When ped_count is zero it forms -win_sum in Q8 instead.
// ----------------------------------------------------------------------------
`default_nettype none

module psci_calc import psci_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_W-1:0]    ped_sum,
  input  logic [SUM_W-1:0]    win_sum,
  input  logic [CNT_W-1:0]    ped_count,
  input  logic [CNT_W-1:0]    int_count,
  input  logic                out_free,
  output calc_stat_t          stat,
  output logic [CHARGE_W-1:0] charge
);

  calc_state_t state;
  calc_state_t state_next;

  logic [ACC_W-1:0]  acc;
  logic [SUM_W:0]    diff;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [DIV_W-1:0]  quot;
  logic              neg;

  logic [ACC_W-1:0]  alu_a;
  logic [ACC_W-1:0]  alu_b;
  alu_op_t           alu_op;
  logic [ACC_W-1:0]  alu_y;

  logic [ACC_W-1:0]  ps_x;
  logic [ACC_W-1:0]  ws_x;
  logic [ACC_W-1:0]  diff_x;
  logic [REM_W:0]    rem_shift;
  logic [ACC_W-1:0]  mag;
  logic              int_bit;
  logic              ped_bit;
  logic              ovf;

  assign ps_x      = {{(ACC_W-SUM_W){ped_sum[SUM_W-1]}}, ped_sum};
  assign ws_x      = {{(ACC_W-SUM_W){win_sum[SUM_W-1]}}, win_sum};
  assign diff_x    = {{(ACC_W-SUM_W-1){diff[SUM_W]}}, diff};
  assign rem_shift = {rem, quot[DIV_W-1]};
  assign int_bit   = int_count[step[3:0]];
  assign ped_bit   = ped_count[step[3:0]];
  assign mag       = acc[ACC_W-1] ? alu_y : acc;

  psci_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_op     = ALU_ADD;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        alu_a      = ps_x;
        alu_b      = ws_x;
        alu_op     = ALU_SUB;
        state_next = (ped_count == '0) ? S_NEGW : S_MUL;
      end
      S_NEGW: begin
        alu_b      = ws_x;
        alu_op     = ALU_SUB;
        state_next = S_DONE;
      end
      S_MUL: begin
        // Horner step over the bits of both counts, most significant first.
        alu_a = {acc[ACC_W-2:0], 1'b0};
        case ({int_bit, ped_bit})
          2'b11: alu_b = diff_x;
          2'b10: alu_b = ps_x;
          2'b01: begin
            alu_b  = ws_x;
            alu_op = ALU_SUB;
          end
          default: alu_b = '0;
        endcase
        if (step == '0) begin
          state_next = S_ABS;
        end
      end
      S_ABS: begin
        alu_b      = acc;
        alu_op     = ALU_SUB;
        state_next = S_DIV;
      end
      S_DIV: begin
        alu_a  = {{(ACC_W-REM_W-1){1'b0}}, rem_shift};
        alu_b  = {{(ACC_W-CNT_W){1'b0}}, ped_count};
        alu_op = ALU_SUB;
        if (step == '0) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        alu_b      = {1'b0, quot};
        alu_op     = ALU_SUB;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_DIFF: begin
        diff <= alu_y[SUM_W:0];
        acc  <= '0;
        step <= STEP_W'(CNT_W - 1);
      end
      S_NEGW: begin
        acc <= {alu_y[ACC_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}};
      end
      S_MUL: begin
        acc  <= alu_y;
        step <= step - 1'b1;
      end
      S_ABS: begin
        neg  <= acc[ACC_W-1];
        quot <= {mag[DIV_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}};
        rem  <= '0;
        step <= STEP_W'(DIV_W - 1);
      end
      S_DIV: begin
        // Restoring division: keep the trial difference when it is not negative.
        quot <= {quot[DIV_W-2:0], ~alu_y[ACC_W-1]};
        rem  <= alu_y[ACC_W-1] ? rem_shift[REM_W-1:0] : alu_y[REM_W-1:0];
        step <= step - 1'b1;
      end
      S_SIGN: begin
        acc <= neg ? alu_y : {1'b0, quot};
      end
      default: ;
    endcase
  end

  // The signed result overflows when the output's sign bit and the bits above it are not all equal.
  assign ovf    = ~(&acc[ACC_W-1:CHARGE_W-1]) && (|acc[ACC_W-1:CHARGE_W-1]);
  assign charge = !ovf           ? acc[CHARGE_W-1:0] :
                  acc[ACC_W-1]   ? {1'b1, {(CHARGE_W-1){1'b0}}} :
                                   {1'b0, {(CHARGE_W-1){1'b1}}};

  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE) && out_free;

endmodule

`default_nettype wire

// ===== sim/pedestal_subtracted_charge_integrator_tb.sv =====
// ----------------------------------------------------------------------------
// pedestal_subtracted_charge_integrator_tb: self-checking bench for the
// charge integrator
// Streams tagged samples into the block. It covers the default windows,
// window edges, a zero pedestal count, charge saturation, wrapping sums and
// random events. Every input beat goes through a local model of the two sums
// and the event counter. Each output beat is compared field by field with
// the oldest predicted charge. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module pedestal_subtracted_charge_integrator_tb;
  import psci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  // Settling time after the last charge, before new writes.
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS = 400;
  localparam int WRAP_ITEMS = 2050;
  localparam int MAX_REPORTS = 10;
  // Index past the register list; writes to it must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

  localparam longint CHARGE_MAX = (longint'(1) <<< (CHARGE_W - 1)) - 1;
  localparam longint CHARGE_MIN = -(longint'(1) <<< (CHARGE_W - 1));

  typedef struct packed {
    logic [CHARGE_W-1:0] charge;
    logic [EVT_W-1:0]    evt;
  } charge_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // s_tdata: adc_value[15:0], chan_index[20:16], time_index[30:21], zero pad
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // m_tdata: charge_q8[34:0], event_number[50:35], zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Local copy of the configuration and of the accumulator state.
  logic [CHAN_W-1:0] sel_chan   = RST_CHANNEL_SELECT;
  logic [TIME_W-1:0] ped_start  = RST_PED_FIRST;
  logic [CNT_W-1:0]  ped_len    = RST_PED_COUNT;
  logic [TIME_W-1:0] win_start  = RST_INT_FIRST;
  logic [CNT_W-1:0]  win_len    = RST_INT_COUNT;
  logic [SUM_W-1:0]  ped_acc    = '0;
  logic [SUM_W-1:0]  win_acc    = '0;
  logic [EVT_W-1:0]  events_done = '0;

  charge_beat_t pending_charges[$];

  bit quiet_mode = 1'b0;
  int mismatches = 0;
  int beats_sent = 0;
  int charges_checked = 0;
  int settings_used = 0;
  longint cycles = 0;

  pedestal_subtracted_charge_integrator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d charges outstanding", cycles,
               pending_charges.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit in_window(logic [TIME_W-1:0] t, logic [TIME_W-1:0] first,
                                   logic [CNT_W-1:0] count);
    return (t >= first) && ((int'(t) - int'(first)) < int'(count));
  endfunction

  // Accumulate one accepted sample and, on an event end, queue its charge.
  task automatic integrate_sample(logic [ADC_W-1:0] adc, logic [CHAN_W-1:0] chan,
                                  logic [TIME_W-1:0] t, logic eoe);
    logic [SUM_W-1:0] smp;
    longint ps, ws, num, q;
    charge_beat_t beat;
    smp = {{(SUM_W - ADC_W){adc[ADC_W-1]}}, adc};
    if (chan == sel_chan && int'(chan) < NUM_CHANNELS && int'(t) < TIME_SAMPLES) begin
      if (in_window(t, ped_start, ped_len)) ped_acc = ped_acc + smp;
      if (in_window(t, win_start, win_len)) win_acc = win_acc + smp;
    end
    if (eoe) begin
      ps = $signed(ped_acc);
      ws = $signed(win_acc);
      if (ped_len == 0) begin
        q = -ws * 256;
      end else begin
        num = (longint'(win_len) * ps - ws * longint'(ped_len)) * 256;
        q = num / longint'(ped_len);
      end
      if (q > CHARGE_MAX) q = CHARGE_MAX;
      if (q < CHARGE_MIN) q = CHARGE_MIN;
      beat.charge = q[CHARGE_W-1:0];
      beat.evt = events_done;
      pending_charges.push_back(beat);
      ped_acc = '0;
      win_acc = '0;
      events_done = events_done + 1'b1;
    end
  endtask

  task automatic send_sample(logic [ADC_W-1:0] adc, logic [CHAN_W-1:0] chan,
                             logic [TIME_W-1:0] t, logic eoe);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, t, chan, adc};
    s_tlast <= eoe;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    integrate_sample(adc, chan, t, eoe);
    beats_sent++;
  endtask

  // Hold the input until every charge has come out, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_charges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers plus one unmapped index; called only when idle.
  task automatic write_config(logic [CFG_DATA_W-1:0] ch, logic [CFG_DATA_W-1:0] pf,
                              logic [CFG_DATA_W-1:0] pc, logic [CFG_DATA_W-1:0] wf,
                              logic [CFG_DATA_W-1:0] wc);
    logic [CFG_DATA_W-1:0] vals[5];
    cfg_reg_t idx[5];
    vals = '{ch, pf, pc, wf, wc};
    idx = '{REG_CHANNEL_SELECT, REG_PED_FIRST, REG_PED_COUNT, REG_INT_FIRST,
            REG_INT_COUNT};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_addr <= REG_UNMAPPED;
    cfg_data <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sel_chan  = ch[CHAN_W-1:0];
    ped_start = pf[TIME_W-1:0];
    ped_len   = pc[CNT_W-1:0];
    win_start = wf[TIME_W-1:0];
    win_len   = wc[CNT_W-1:0];
    settings_used++;
    @(posedge clk);
  endtask

  // Receiver side: runs of ready broken by random stalls.
  initial begin
    int run, stall;
    forever begin
      if (quiet_mode) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 12);
        m_tready <= 1'b1;
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    charge_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_charges.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output beat: charge %h event %0d",
                   m_tdata[CHARGE_W-1:0], m_tdata[CHARGE_W+EVT_W-1:CHARGE_W]);
      end else begin
        want = pending_charges.pop_front();
        charges_checked++;
        if (m_tdata[CHARGE_W-1:0] !== want.charge ||
            m_tdata[CHARGE_W+EVT_W-1:CHARGE_W] !== want.evt) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("event %0d: charge exp %h got %h, number exp %0d got %0d",
                     want.evt, want.charge, m_tdata[CHARGE_W-1:0], want.evt,
                     m_tdata[CHARGE_W+EVT_W-1:CHARGE_W]);
        end
      end
    end
  end

  // Reset windows; one event ends on a beat of another channel.
  task automatic test_default_windows();
    send_sample(16'h7FFF, 5'd0, 10'd1, 1'b0);
    send_sample(16'h8000, 5'd0, 10'd50, 1'b0);
    send_sample(16'h1234, 5'd0, 10'd0, 1'b0);
    send_sample(16'h0F0F, 5'd0, 10'd51, 1'b0);
    send_sample(16'h7FFF, 5'd0, 10'd399, 1'b0);
    send_sample(16'h8000, 5'd0, 10'd400, 1'b0);
    send_sample(16'h5555, 5'd31, 10'd1023, 1'b0);
    send_sample(16'hFFFF, 5'd31, 10'd1023, 1'b1);
    send_sample(16'h0100, 5'd0, 10'd10, 1'b1);
    drain();
  endtask

  // Windows cut short at the last time index, and masked register writes.
  task automatic test_window_edges();
    write_config(11'h7FF, 11'h7FF, 11'd1024, 11'd1000, 11'd1024);
    send_sample(16'h2AAA, 5'd31, 10'd1023, 1'b0);
    send_sample(16'h8001, 5'd31, 10'd1000, 1'b0);
    send_sample(16'h4000, 5'd31, 10'd999, 1'b1);
    drain();
  endtask

  task automatic test_zero_pedestal();
    write_config(11'd4, 11'd0, 11'd0, 11'd0, 11'd1);
    send_sample(16'h00FF, 5'd4, 10'd0, 1'b0);
    send_sample(16'hFFFE, 5'd4, 10'd5, 1'b1);
    drain();
  endtask

  // One pedestal sample repeated drives the charge to either rail.
  task automatic test_saturation();
    write_config(11'd9, 11'd5, 11'd1, 11'd600, 11'd1024);
    for (int i = 0; i < 5; i++) send_sample(16'h7FFF, 5'd9, 10'd5, i == 4);
    for (int i = 0; i < 5; i++) send_sample(16'h8000, 5'd9, 10'd5, i == 4);
    drain();
  endtask

  // A long event on one repeated time index wraps both 27-bit sums.
  task automatic test_sum_wrap();
    write_config(11'd3, 11'd7, 11'd1, 11'd7, 11'd1);
    quiet_mode = 1'b1;
    for (int i = 0; i < WRAP_ITEMS; i++)
      send_sample(16'h8000, 5'd3, 10'd7, i == WRAP_ITEMS - 1);
    quiet_mode = 1'b0;
    drain();
  endtask

  function automatic logic [ADC_W-1:0] rand_adc();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    return ADC_W'($urandom());
  endfunction

  // Mostly well-formed events of the selected channel inside the windows,
  // with some noise beats and stray event ends mixed in.
  task automatic test_random_events();
    int sent, phase, len, lo, hi, ch;
    logic [CFG_DATA_W-1:0] pf, pc, wf, wc, cs;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] t;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          cs = 11'd31; pf = 11'd0; pc = 11'd1024; wf = 11'd0; wc = 11'd1024;
        end
        1: begin
          cs = 11'd0; pf = 11'd1023; pc = 11'd1; wf = 11'd1023; wc = 11'd1;
        end
        default: begin
          cs = 11'($urandom_range(0, 31));
          pf = 11'($urandom_range(0, 1000));
          pc = ($urandom_range(0, 7) == 0) ? 11'd1024 : 11'($urandom_range(1, 64));
          wf = 11'($urandom_range(0, 1000));
          wc = ($urandom_range(0, 7) == 0) ? 11'd1024 : 11'($urandom_range(1, 200));
        end
      endcase
      write_config(cs, pf, pc, wf, wc);
      lo = (pf < wf) ? int'(pf) : int'(wf);
      hi = (int'(pf) + int'(pc) > int'(wf) + int'(wc)) ? int'(pf) + int'(pc)
                                                       : int'(wf) + int'(wc);
      if (hi > 1023) hi = 1023;
      quiet_mode = (phase == 2);
      for (int k = 0; k < RANDOM_ITEMS / 6 && sent < RANDOM_ITEMS; ) begin
        len = $urandom_range(1, 30);
        if ($urandom_range(0, 4) != 0) begin
          for (int j = 0; j < len; j++) begin
            ch = ($urandom_range(0, 3) != 0) ? int'(sel_chan) : $urandom_range(0, 31);
            chan = CHAN_W'(ch);
            t = ($urandom_range(0, 4) != 0) ? TIME_W'($urandom_range(lo, hi))
                                            : TIME_W'($urandom_range(0, 1023));
            send_sample(rand_adc(), chan, t, j == len - 1);
          end
        end else begin
          for (int j = 0; j < len; j++)
            send_sample(rand_adc(), CHAN_W'($urandom()), TIME_W'($urandom()),
                        $urandom_range(0, 9) == 0);
        end
        k += len;
        sent += len;
        // Occasionally hold the input until the outstanding charges are out.
        if ($urandom_range(0, 15) == 0) begin
          s_tvalid <= 1'b0;
          while (pending_charges.size() != 0) @(posedge clk);
        end
      end
      quiet_mode = 1'b0;
      drain();
      phase++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_windows();
    test_window_edges();
    test_zero_pedestal();
    test_saturation();
    test_sum_wrap();
    test_random_events();
    drain();
    $display("sent %0d samples, checked %0d event charges over %0d register settings",
             beats_sent, charges_checked, settings_used);
    $display("covered default, edge, zero-pedestal, saturating and wrapping windows");
    if (mismatches == 0 && pending_charges.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d charges never seen", mismatches,
               pending_charges.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/psci_pkg.sv
hw/rtl/psci_alu.sv
hw/rtl/psci_accum.sv
hw/rtl/psci_calc.sv
hw/rtl/pedestal_subtracted_charge_integrator.sv
sim/pedestal_subtracted_charge_integrator_tb.sv
